### hdl/pau_pkg.sv
// Shared types and codes for the Pareto archive update block.
// No dependencies; used by pau_cmp and pareto_archive_update.
`default_nettype none

package pau_pkg;

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_EVAL   = 6'b000100,
        S_APPEND = 6'b001000,
        S_RDREQ  = 6'b010000,
        S_RDOUT  = 6'b100000
    } state_t;

    typedef struct packed {
        logic cand_dom;     // candidate strictly dominates the entry
        logic entry_cover;  // entry dominates or equals the candidate
    } dom_t;

endpackage

`default_nettype wire

### hdl/pau_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/pau_cmp.sv
// Shared dominance compare unit: one candidate point against one stored entry.
// Depends on pau_pkg for the dom_t result struct.
`default_nettype none

module pau_cmp #(
    parameter int OBJ_WIDTH = 32
) (
    input  wire logic [OBJ_WIDTH-1:0] cand_a,
    input  wire logic [OBJ_WIDTH-1:0] cand_b,
    input  wire logic [OBJ_WIDTH-1:0] entry_a,
    input  wire logic [OBJ_WIDTH-1:0] entry_b,
    output pau_pkg::dom_t             result
);

    logic c_le_a;
    logic c_le_b;
    logic e_le_a;
    logic e_le_b;

    assign c_le_a = cand_a <= entry_a;
    assign c_le_b = cand_b <= entry_b;
    assign e_le_a = entry_a <= cand_a;
    assign e_le_b = entry_b <= cand_b;

    assign result.cand_dom    = c_le_a && c_le_b && !(e_le_a && e_le_b);
    assign result.entry_cover = e_le_a && e_le_b;

endmodule

`default_nettype wire

### hdl/pareto_archive_update.sv
// Top level of the bounded two-objective Pareto archive.
// Depends on pau_pkg, pau_ram and pau_cmp.
//
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and the receiver cannot stall
// it. An offer (cmd 0) walks the stored entries once through a single compare
// unit, each entry in turn (RAM read, then compare and compacting write),
// and then appends the candidate if no entry covers it and there is room. A
// read (cmd 1) goes through the registered RAM read. busy stays high meanwhile.
// The archive RAM needs no clearing after reset; only entries below the fill
// count are ever read.
`default_nettype none

module pareto_archive_update #(
    parameter int ARCHIVE_DEPTH = 64,
    parameter int OBJ_WIDTH     = 32,
    parameter int TAG_WIDTH     = 16,
    localparam int IDX_W        = $clog2(ARCHIVE_DEPTH),
    localparam int CNT_W        = $clog2(ARCHIVE_DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 cmd,
    input  wire logic [OBJ_WIDTH-1:0] obj_a,
    input  wire logic [OBJ_WIDTH-1:0] obj_b,
    input  wire logic [TAG_WIDTH-1:0] sol_tag,
    input  wire logic [IDX_W-1:0]     read_index,
    output logic                      done,
    output logic                      inserted,
    output logic [CNT_W-1:0]          removed_count,
    output logic [CNT_W-1:0]          archive_count,
    output logic                      full_drop,
    output logic                      entry_valid,
    output logic [OBJ_WIDTH-1:0]      entry_a,
    output logic [OBJ_WIDTH-1:0]      entry_b,
    output logic [TAG_WIDTH-1:0]      entry_tag
);

    localparam int RAM_W = 2 * OBJ_WIDTH + TAG_WIDTH;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ARCHIVE_DEPTH);

    pau_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             add_reg, add_next;
    logic             rd_ok_reg, rd_ok_next;
    logic             done_reg, done_next;

    logic [OBJ_WIDTH-1:0] cand_a_reg, cand_a_next;
    logic [OBJ_WIDTH-1:0] cand_b_reg, cand_b_next;
    logic [TAG_WIDTH-1:0] cand_tag_reg, cand_tag_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;

    logic                 inserted_reg, inserted_next;
    logic [CNT_W-1:0]     removed_count_reg, removed_count_next;
    logic [CNT_W-1:0]     archive_count_reg, archive_count_next;
    logic                 full_drop_reg, full_drop_next;
    logic                 entry_valid_reg, entry_valid_next;
    logic [OBJ_WIDTH-1:0] entry_a_reg, entry_a_next;
    logic [OBJ_WIDTH-1:0] entry_b_reg, entry_b_next;
    logic [TAG_WIDTH-1:0] entry_tag_reg, entry_tag_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [RAM_W-1:0] ram_rdata;

    logic [OBJ_WIDTH-1:0] ent_a;
    logic [OBJ_WIDTH-1:0] ent_b;
    logic [TAG_WIDTH-1:0] ent_tag;
    logic [CNT_W-1:0]     idx_inc;
    pau_pkg::dom_t        dom;

    assign ent_a   = ram_rdata[RAM_W-1 -: OBJ_WIDTH];
    assign ent_b   = ram_rdata[TAG_WIDTH +: OBJ_WIDTH];
    assign ent_tag = ram_rdata[TAG_WIDTH-1:0];
    assign idx_inc = idx_reg + CNT_W'(1);

    pau_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ARCHIVE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pau_cmp #(
        .OBJ_WIDTH (OBJ_WIDTH)
    ) u_cmp (
        .cand_a  (cand_a_reg),
        .cand_b  (cand_b_reg),
        .entry_a (ent_a),
        .entry_b (ent_b),
        .result  (dom)
    );

    always_comb
    begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        kept_next          = kept_reg;
        removed_next       = removed_reg;
        count_next         = count_reg;
        add_next           = add_reg;
        rd_ok_next         = rd_ok_reg;
        done_next          = 1'b0;
        cand_a_next        = cand_a_reg;
        cand_b_next        = cand_b_reg;
        cand_tag_next      = cand_tag_reg;
        rd_idx_next        = rd_idx_reg;
        inserted_next      = inserted_reg;
        removed_count_next = removed_count_reg;
        archive_count_next = archive_count_reg;
        full_drop_next     = full_drop_reg;
        entry_valid_next   = entry_valid_reg;
        entry_a_next       = entry_a_reg;
        entry_b_next       = entry_b_reg;
        entry_tag_next     = entry_tag_reg;
        ram_we             = 1'b0;
        ram_waddr          = kept_reg[IDX_W-1:0];
        ram_wdata          = ram_rdata;
        ram_re             = 1'b0;
        ram_raddr          = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            pau_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cand_a_next   = obj_a;
                    cand_b_next   = obj_b;
                    cand_tag_next = sol_tag;
                    rd_idx_next   = read_index;
                    idx_next      = '0;
                    kept_next     = '0;
                    removed_next  = '0;
                    add_next      = 1'b1;
                    rd_ok_next    = CNT_W'(read_index) < count_reg;
                    if (cmd == pau_pkg::CMD_READ)
                    begin
                        state_next = pau_pkg::S_RDREQ;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = pau_pkg::S_APPEND;
                    end
                    else
                    begin
                        state_next = pau_pkg::S_READ;
                    end
                end
            end
            pau_pkg::S_READ:
            begin
                ram_re     = 1'b1;
                state_next = pau_pkg::S_EVAL;
            end
            pau_pkg::S_EVAL:
            begin
                // drop dominated entries, compact the survivors downward
                if (dom.cand_dom)
                begin
                    removed_next = removed_reg + CNT_W'(1);
                end
                else
                begin
                    ram_we    = 1'b1;
                    kept_next = kept_reg + CNT_W'(1);
                end
                if (dom.entry_cover)
                begin
                    add_next = 1'b0;
                end
                idx_next = idx_inc;
                if (idx_inc == count_reg)
                begin
                    state_next = pau_pkg::S_APPEND;
                end
                else
                begin
                    state_next = pau_pkg::S_READ;
                end
            end
            pau_pkg::S_APPEND:
            begin
                ram_wdata          = {cand_a_reg, cand_b_reg, cand_tag_reg};
                inserted_next      = 1'b0;
                full_drop_next     = 1'b0;
                count_next         = kept_reg;
                if (add_reg && (kept_reg < DEPTH_CNT))
                begin
                    ram_we        = 1'b1;
                    count_next    = kept_reg + CNT_W'(1);
                    inserted_next = 1'b1;
                end
                else if (add_reg)
                begin
                    full_drop_next = 1'b1;
                end
                removed_count_next = removed_reg;
                archive_count_next = count_next;
                entry_valid_next   = 1'b0;
                entry_a_next       = '0;
                entry_b_next       = '0;
                entry_tag_next     = '0;
                done_next          = 1'b1;
                state_next         = pau_pkg::S_IDLE;
            end
            pau_pkg::S_RDREQ:
            begin
                ram_re     = rd_ok_reg;
                ram_raddr  = rd_idx_reg;
                state_next = pau_pkg::S_RDOUT;
            end
            pau_pkg::S_RDOUT:
            begin
                inserted_next      = 1'b0;
                removed_count_next = '0;
                full_drop_next     = 1'b0;
                archive_count_next = count_reg;
                entry_valid_next   = rd_ok_reg;
                entry_a_next       = rd_ok_reg ? ent_a : '0;
                entry_b_next       = rd_ok_reg ? ent_b : '0;
                entry_tag_next     = rd_ok_reg ? ent_tag : '0;
                done_next          = 1'b1;
                state_next         = pau_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pau_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pau_pkg::S_IDLE;
            idx_reg     <= '0;
            kept_reg    <= '0;
            removed_reg <= '0;
            count_reg   <= '0;
            add_reg     <= 1'b0;
            rd_ok_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            kept_reg    <= kept_next;
            removed_reg <= removed_next;
            count_reg   <= count_next;
            add_reg     <= add_next;
            rd_ok_reg   <= rd_ok_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_a_reg        <= cand_a_next;
        cand_b_reg        <= cand_b_next;
        cand_tag_reg      <= cand_tag_next;
        rd_idx_reg        <= rd_idx_next;
        inserted_reg      <= inserted_next;
        removed_count_reg <= removed_count_next;
        archive_count_reg <= archive_count_next;
        full_drop_reg     <= full_drop_next;
        entry_valid_reg   <= entry_valid_next;
        entry_a_reg       <= entry_a_next;
        entry_b_reg       <= entry_b_next;
        entry_tag_reg     <= entry_tag_next;
    end

    assign busy          = (state_reg != pau_pkg::S_IDLE);
    assign done          = done_reg;
    assign inserted      = inserted_reg;
    assign removed_count = removed_count_reg;
    assign archive_count = archive_count_reg;
    assign full_drop     = full_drop_reg;
    assign entry_valid   = entry_valid_reg;
    assign entry_a       = entry_a_reg;
    assign entry_b       = entry_b_reg;
    assign entry_tag     = entry_tag_reg;

`ifndef NO_ASSERTIONS
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("fill count beyond archive depth");

    a_kept_behind: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= idx_reg)
        else $error("compaction write ahead of read pointer");

    a_ins_or_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(inserted && full_drop))
        else $error("candidate both inserted and dropped");
`endif

endmodule

`default_nettype wire

### tb/pau_archive_checker.sv
`timescale 1ns / 1ps
// Checker for the Pareto archive update block: watches requests and results,
// keeps its own copy of the archive and compares every result in order.
// Depends on pau_pkg for the command codes.

module pau_archive_checker #(
    parameter int DEPTH = 64,
    parameter int OBJ_W = 32,
    parameter int TAG_W = 16,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire logic             cmd,
    input  wire logic [OBJ_W-1:0] obj_a,
    input  wire logic [OBJ_W-1:0] obj_b,
    input  wire logic [TAG_W-1:0] sol_tag,
    input  wire logic [IDX_W-1:0] read_index,
    input  wire logic             done,
    input  wire logic             inserted,
    input  wire logic [CNT_W-1:0] removed_count,
    input  wire logic [CNT_W-1:0] archive_count,
    input  wire logic             full_drop,
    input  wire logic             entry_valid,
    input  wire logic [OBJ_W-1:0] entry_a,
    input  wire logic [OBJ_W-1:0] entry_b,
    input  wire logic [TAG_W-1:0] entry_tag,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic             inserted;
        logic [CNT_W-1:0] removed_count;
        logic [CNT_W-1:0] archive_count;
        logic             full_drop;
        logic             entry_valid;
        logic [OBJ_W-1:0] entry_a;
        logic [OBJ_W-1:0] entry_b;
        logic [TAG_W-1:0] entry_tag;
    } archive_result_t;

    logic [OBJ_W-1:0] arc_a   [DEPTH];
    logic [OBJ_W-1:0] arc_b   [DEPTH];
    logic [TAG_W-1:0] arc_tag [DEPTH];
    int               arc_fill;
    archive_result_t  outcome_q [$];

    function automatic bit pareto_better(input logic [OBJ_W-1:0] pa, pb, qa, qb);
        return (pa <= qa) && (pb <= qb) && ((pa < qa) || (pb < qb));
    endfunction

    function automatic archive_result_t apply_request(
        input logic             c,
        input logic [OBJ_W-1:0] ca,
        input logic [OBJ_W-1:0] cb,
        input logic [TAG_W-1:0] ct,
        input logic [IDX_W-1:0] idx
    );
        archive_result_t res;
        int              kept;
        int              removed;
        bit              covered;
        res = '0;
        if (c == pau_pkg::CMD_READ)
        begin
            res.archive_count = CNT_W'(arc_fill);
            if (int'(idx) < arc_fill)
            begin
                res.entry_valid = 1'b1;
                res.entry_a     = arc_a[idx];
                res.entry_b     = arc_b[idx];
                res.entry_tag   = arc_tag[idx];
            end
            return res;
        end
        kept    = 0;
        removed = 0;
        for (int i = 0; i < arc_fill; i++)
        begin
            if (pareto_better(ca, cb, arc_a[i], arc_b[i]))
                removed++;
            else
            begin
                arc_a[kept]   = arc_a[i];
                arc_b[kept]   = arc_b[i];
                arc_tag[kept] = arc_tag[i];
                kept++;
            end
        end
        arc_fill = kept;
        covered  = 1'b0;
        for (int i = 0; i < arc_fill; i++)
        begin
            if (pareto_better(arc_a[i], arc_b[i], ca, cb) || (arc_a[i] == ca && arc_b[i] == cb))
                covered = 1'b1;
        end
        if (!covered)
        begin
            if (arc_fill < DEPTH)
            begin
                arc_a[arc_fill]   = ca;
                arc_b[arc_fill]   = cb;
                arc_tag[arc_fill] = ct;
                arc_fill++;
                res.inserted = 1'b1;
            end
            else
                res.full_drop = 1'b1;
        end
        res.removed_count = CNT_W'(removed);
        res.archive_count = CNT_W'(arc_fill);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        archive_result_t want;
        archive_result_t got;
        if (!rst_n)
        begin
            arc_fill   = 0;
            fail_count = 0;
            pending    = 0;
            outcome_q.delete();
            for (int i = 0; i < DEPTH; i++)
            begin
                arc_a[i]   = '0;
                arc_b[i]   = '0;
                arc_tag[i] = '0;
            end
        end
        else
        begin
            if (done)
            begin
                got = '{inserted, removed_count, archive_count, full_drop,
                        entry_valid, entry_a, entry_b, entry_tag};
                if (outcome_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with no request outstanding", $realtime);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch expected ins=%0d rem=%0d cnt=%0d drop=%0d vld=%0d a=%h b=%h tag=%h",
                                     $realtime,
                                     want.inserted, want.removed_count, want.archive_count,
                                     want.full_drop, want.entry_valid, want.entry_a,
                                     want.entry_b, want.entry_tag);
                            $display("%0t: mismatch actual   ins=%0d rem=%0d cnt=%0d drop=%0d vld=%0d a=%h b=%h tag=%h",
                                     $realtime,
                                     got.inserted, got.removed_count, got.archive_count,
                                     got.full_drop, got.entry_valid, got.entry_a,
                                     got.entry_b, got.entry_tag);
                        end
                    end
                end
            end
            if (start && !busy)
                outcome_q.insert(outcome_q.size(),
                                 apply_request(cmd, obj_a, obj_b, sol_tag, read_index));
            pending = outcome_q.size();
        end
    end

endmodule

### tb/pareto_archive_update_test.sv
`timescale 1ns / 1ps
// Top of the Pareto archive update testbench: clock, reset, directed and
// random requests, watchdog and verdict. Depends on pau_pkg and pau_archive_checker.

module pareto_archive_update_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * 64 + 16;
    localparam int RANDOM_ITEMS   = 480;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [31:0] obj_a;
    logic [31:0] obj_b;
    logic [15:0] sol_tag;
    logic [5:0]  read_index;
    logic        done;
    logic        inserted;
    logic [6:0]  removed_count;
    logic [6:0]  archive_count;
    logic        full_drop;
    logic        entry_valid;
    logic [31:0] entry_a;
    logic [31:0] entry_b;
    logic [15:0] entry_tag;

    int          fail_count;
    int          pending;
    int          stall_cycles = 0;
    logic [6:0]  seen_count;
    bit          no_idle = 1'b0;

    pareto_archive_update dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .obj_a         (obj_a),
        .obj_b         (obj_b),
        .sol_tag       (sol_tag),
        .read_index    (read_index),
        .done          (done),
        .inserted      (inserted),
        .removed_count (removed_count),
        .archive_count (archive_count),
        .full_drop     (full_drop),
        .entry_valid   (entry_valid),
        .entry_a       (entry_a),
        .entry_b       (entry_b),
        .entry_tag     (entry_tag)
    );

    pau_archive_checker archive_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .obj_a         (obj_a),
        .obj_b         (obj_b),
        .sol_tag       (sol_tag),
        .read_index    (read_index),
        .done          (done),
        .inserted      (inserted),
        .removed_count (removed_count),
        .archive_count (archive_count),
        .full_drop     (full_drop),
        .entry_valid   (entry_valid),
        .entry_a       (entry_a),
        .entry_b       (entry_b),
        .entry_tag     (entry_tag),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_count <= '0;
        else if (done)
            seen_count <= archive_count;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 30);
        return $urandom_range(31, 150);
    endfunction

    function automatic logic [5:0] pick_index();
        if ($urandom_range(0, 1) == 0 || seen_count == 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, int'(seen_count) - 1));
    endfunction

    // Call at a falling edge; returns at a falling edge after acceptance.
    task automatic issue_request(
        input logic        c,
        input logic [31:0] a,
        input logic [31:0] b,
        input logic [15:0] t,
        input logic [5:0]  idx
    );
        int gap;
        while (busy)
            @(negedge clk);
        start      = 1'b1;
        cmd        = c;
        obj_a      = a;
        obj_b      = b;
        sol_tag    = t;
        read_index = idx;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start      = 1'b0;
            cmd        = 1'($urandom);
            obj_a      = $urandom;
            obj_b      = $urandom;
            sol_tag    = 16'($urandom);
            read_index = 6'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic read_entry(input logic [5:0] idx);
        issue_request(pau_pkg::CMD_READ, $urandom, $urandom, 16'($urandom), idx);
    endtask

    task automatic offer_point(input logic [31:0] a, input logic [31:0] b, input logic [15:0] t);
        issue_request(pau_pkg::CMD_OFFER, a, b, t, 6'($urandom));
    endtask

    initial
    begin
        int          items_sent;
        int          phase_len;
        int          r;
        int unsigned span;
        int unsigned step;
        int unsigned base_a;
        int unsigned base_b;
        int unsigned sweep;
        int unsigned k;
        int unsigned m;

        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = pau_pkg::CMD_OFFER;
        obj_a      = '0;
        obj_b      = '0;
        sol_tag    = '0;
        read_index = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        read_entry(6'd0);
        read_entry(6'd63);
        offer_point('1, '1, 16'hFFFF);
        offer_point('1, '1, 16'h1234);
        offer_point('1, 32'hFFFF_FFFE, 16'h0001);
        offer_point('0, '1, 16'hA5A5);
        offer_point('1, '0, 16'h5A5A);
        read_entry(6'd0);
        read_entry(6'd1);
        read_entry(6'd2);
        read_entry(6'd3);
        read_entry(6'd63);
        offer_point('0, '0, 16'h0000);
        offer_point(32'd1, '0, 16'h00FF);
        offer_point('0, 32'd1, 16'hFF00);
        offer_point('0, '0, 16'hC3C3);
        offer_point(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
        read_entry(6'd0);
        offer_point(32'h0000_0000, 32'h0000_0000, 16'h7FFF);
        read_entry(6'd1);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(100, 160);
            if (phase_len > RANDOM_ITEMS - items_sent)
                phase_len = RANDOM_ITEMS - items_sent;
            span      = $urandom_range(50, 96);
            case ($urandom_range(0, 2))
                0:       step = 1;
                1:       step = 16;
                default: step = 256;
            endcase
            base_a  = $urandom_range(0, 32'hFFFE_0000);
            base_b  = $urandom_range(0, 32'hFFFE_0000);
            sweep   = 0;
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    read_entry(pick_index());
                else if (r < 24)
                    offer_point($urandom, $urandom, 16'($urandom));
                else if (r < 28)
                begin
                    // dominate a run of neighbouring front points
                    k = $urandom_range(0, span - 1);
                    m = $urandom_range(0, span - 1 - k);
                    offer_point(base_a + k * step, base_b + (span - 1 - k - m) * step,
                                16'($urandom));
                end
                else
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        k = sweep % span;
                        sweep++;
                    end
                    else
                        k = $urandom_range(0, span - 1);
                    offer_point(base_a + k * step + $urandom_range(0, 3),
                                base_b + (span - 1 - k) * step + $urandom_range(0, 3),
                                16'($urandom));
                end
                items_sent++;
            end
            if ($urandom_range(0, 2) == 0)
            begin
                // clear the whole front in one request
                offer_point(base_a, base_b, 16'($urandom));
                items_sent++;
            end
        end

        while (busy)
            @(negedge clk);
        start   = 1'b0;
        no_idle = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
hdl/pau_pkg.sv
hdl/pau_ram.sv
hdl/pau_cmp.sv
hdl/pareto_archive_update.sv
tb/pau_archive_checker.sv
tb/pareto_archive_update_test.sv
